[rtl/assert_macros.svh]
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

// The expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("invariant failed");

`endif

[rtl/tcc_pkg.sv]
package tcc_pkg;

  // Field widths of the channel words.
  localparam int unsigned CMD_W  = 1;
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned ROW_W  = 3;
  localparam int unsigned COL_W  = 5;

  // Default geometry.
  localparam int unsigned ROWS_DEF     = 8;
  localparam int unsigned COLUMNS_DEF  = 21;
  localparam int unsigned TAB_STOP_DEF = 4;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_PUT   = 1'b0;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 1'b1;

  // Character codes.
  localparam logic [CHAR_W-1:0] CH_NL    = 8'd10;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;
  localparam logic [CHAR_W-1:0] CH_END   = 8'd0;

  // Kind of cursor move done by the advance unit.
  typedef enum logic {
    ADV_COLUMN,
    ADV_LINE
  } adv_op_e;

endpackage

[rtl/tcc_in_if.sv]
interface tcc_in_if;
  logic                        valid;
  logic                        ready;
  logic [tcc_pkg::CMD_W-1:0]   command;
  logic [tcc_pkg::CHAR_W-1:0]  char_code;

  modport source (output valid, command, char_code, input ready);
  modport sink   (input valid, command, char_code, output ready);
endinterface

[rtl/tcc_out_if.sv]
interface tcc_out_if;
  logic                        valid;
  logic                        ready;
  logic [tcc_pkg::ROW_W-1:0]   write_row;
  logic [tcc_pkg::COL_W-1:0]   write_column;
  logic [tcc_pkg::CHAR_W-1:0]  write_char;
  logic [tcc_pkg::ROW_W-1:0]   top_row;
  logic                        last;

  modport source (output valid, write_row, write_column, write_char, top_row, last,
                  input ready);
  modport sink   (input valid, write_row, write_column, write_char, top_row, last,
                  output ready);
endinterface

[rtl/tcc_adv.sv]
// Cursor advance unit: moves the cursor one column or to the next line,
// wrapping rows and scrolling the top row once the screen has filled.
module tcc_adv #(
  parameter int unsigned ROWS     = tcc_pkg::ROWS_DEF,
  parameter int unsigned COLUMNS  = tcc_pkg::COLUMNS_DEF,
  parameter int unsigned TAB_STOP = tcc_pkg::TAB_STOP_DEF
) (
  input  tcc_pkg::adv_op_e         op_i,
  input  logic [$clog2(ROWS)-1:0]     row_i,
  input  logic [$clog2(COLUMNS)-1:0]  col_i,
  input  logic [$clog2(TAB_STOP)-1:0] phase_i,
  input  logic                        filled_i,
  input  logic [$clog2(ROWS)-1:0]     top_i,
  output logic [$clog2(ROWS)-1:0]     row_o,
  output logic [$clog2(COLUMNS)-1:0]  col_o,
  output logic [$clog2(TAB_STOP)-1:0] phase_o,
  output logic                        filled_o,
  output logic [$clog2(ROWS)-1:0]     top_o
);

  localparam int unsigned RowW = $clog2(ROWS);
  localparam int unsigned ColW = $clog2(COLUMNS);
  localparam int unsigned PhW  = $clog2(TAB_STOP);

  logic line_wrap;
  logic row_wrap;

  // A newline or a step past the last column starts a new row.
  assign line_wrap = (op_i == tcc_pkg::ADV_LINE) || (col_i == ColW'(COLUMNS - 1));
  assign row_wrap  = (row_i == RowW'(ROWS - 1));

  // Column and tab phase restart at zero on a new row.
  always_comb begin
    if (line_wrap) begin
      col_o   = '0;
      phase_o = '0;
    end else begin
      col_o   = ColW'(col_i + 1'b1);
      phase_o = (phase_i == PhW'(TAB_STOP - 1)) ? '0 : PhW'(phase_i + 1'b1);
    end
  end

  // Row wrap sets the filled flag; a filled screen scrolls on each new row.
  always_comb begin
    row_o    = row_i;
    filled_o = filled_i;
    top_o    = top_i;
    if (line_wrap) begin
      row_o    = row_wrap ? '0 : RowW'(row_i + 1'b1);
      filled_o = filled_i | row_wrap;
      if (filled_i | row_wrap) begin
        top_o = (top_i == RowW'(ROWS - 1)) ? '0 : RowW'(top_i + 1'b1);
      end
    end
  end

endmodule

[rtl/text_console_cursor_scroll.sv]
// Channel | Dir | Word
// --------+-----+------------------------------------------------------------
// in_i    | in  | command, char_code
// out_o   | out | write_row, write_column, write_char, top_row, last
//
// One item at a time; ready is high only while the sequencer is idle.
// A printable character or newline makes one advance pass, then writes its
// character and an end word; a tab makes one pass of the advance unit per space
// to find the final top row, then writes both words per space; a clear writes one end word per row.
// Reset clears the cursor, filled flag, top row and the output register.
// Words are held in the output register until taken; the block waits on it.
`include "assert_macros.svh"

module text_console_cursor_scroll #(
  parameter int unsigned ROWS     = tcc_pkg::ROWS_DEF,
  parameter int unsigned COLUMNS  = tcc_pkg::COLUMNS_DEF,
  parameter int unsigned TAB_STOP = tcc_pkg::TAB_STOP_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  tcc_in_if.sink           in_i,
  tcc_out_if.source        out_o
);

  localparam int unsigned RowW    = $clog2(ROWS);
  localparam int unsigned ColW    = $clog2(COLUMNS);
  localparam int unsigned PhW     = $clog2(TAB_STOP);
  localparam int unsigned CntW    = $clog2(TAB_STOP + 1);
  localparam int unsigned RowOutW = tcc_pkg::ROW_W;
  localparam int unsigned ColOutW = tcc_pkg::COL_W;
  localparam int unsigned CharW   = tcc_pkg::CHAR_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_EMIT_CHAR,
    S_EMIT_END,
    S_CLEAR
  } state_e;

  state_e state_q, state_d;

  // Cursor state and its shadow copy used to look ahead.
  logic [RowW-1:0] row_q, row_d, sh_row_q, sh_row_d;
  logic [ColW-1:0] col_q, col_d, sh_col_q, sh_col_d;
  logic [PhW-1:0]  ph_q, ph_d, sh_ph_q, sh_ph_d;
  logic            filled_q, filled_d, sh_filled_q, sh_filled_d;
  logic [RowW-1:0] top_q, top_d, sh_top_q, sh_top_d;

  // Item registers.
  tcc_pkg::adv_op_e  op_q, op_d;
  logic [CharW-1:0]  char_q, char_d;
  logic [CntW-1:0]   cnt_q, cnt_d, prep_cnt_q, prep_cnt_d;
  logic [RowW-1:0]   final_top_q, final_top_d;
  logic [RowW-1:0]   clr_row_q, clr_row_d;

  // Output register.
  logic               out_valid_q, out_valid_d;
  logic [RowOutW-1:0] o_row_q, o_row_d, o_top_q, o_top_d;
  logic [ColOutW-1:0] o_col_q, o_col_d;
  logic [CharW-1:0]   o_char_q, o_char_d;
  logic               o_last_q, o_last_d;

  // Shared advance unit ports.
  logic [RowW-1:0] a_row_i, a_row_o, a_top_i, a_top_o;
  logic [ColW-1:0] a_col_i, a_col_o;
  logic [PhW-1:0]  a_ph_i, a_ph_o;
  logic            a_filled_i, a_filled_o;

  logic            out_free;
  logic            emit_go;
  logic            emit_last;
  logic [CntW-1:0] tab_cnt;

  // The look-ahead pass runs on the shadow copy, the emit pass on the cursor.
  always_comb begin
    if (state_q == S_PREP) begin
      a_row_i    = sh_row_q;
      a_col_i    = sh_col_q;
      a_ph_i     = sh_ph_q;
      a_filled_i = sh_filled_q;
      a_top_i    = sh_top_q;
    end else begin
      a_row_i    = row_q;
      a_col_i    = col_q;
      a_ph_i     = ph_q;
      a_filled_i = filled_q;
      a_top_i    = top_q;
    end
  end

  tcc_adv #(
    .ROWS     (ROWS),
    .COLUMNS  (COLUMNS),
    .TAB_STOP (TAB_STOP)
  ) u_adv (
    .op_i     (op_q),
    .row_i    (a_row_i),
    .col_i    (a_col_i),
    .phase_i  (a_ph_i),
    .filled_i (a_filled_i),
    .top_i    (a_top_i),
    .row_o    (a_row_o),
    .col_o    (a_col_o),
    .phase_o  (a_ph_o),
    .filled_o (a_filled_o),
    .top_o    (a_top_o)
  );

  assign out_free = !out_valid_q || out_o.ready;
  assign tab_cnt  = CntW'(TAB_STOP) - CntW'(ph_q);

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    row_d       = row_q;
    col_d       = col_q;
    ph_d        = ph_q;
    filled_d    = filled_q;
    top_d       = top_q;
    sh_row_d    = sh_row_q;
    sh_col_d    = sh_col_q;
    sh_ph_d     = sh_ph_q;
    sh_filled_d = sh_filled_q;
    sh_top_d    = sh_top_q;
    op_d        = op_q;
    char_d      = char_q;
    cnt_d       = cnt_q;
    prep_cnt_d  = prep_cnt_q;
    final_top_d = final_top_q;
    clr_row_d   = clr_row_q;
    emit_go     = 1'b0;
    emit_last   = 1'b0;
    o_row_d     = o_row_q;
    o_col_d     = o_col_q;
    o_char_d    = o_char_q;
    o_top_d     = o_top_q;
    o_last_d    = o_last_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          if (in_i.command == tcc_pkg::CMD_CLEAR) begin
            clr_row_d = '0;
            state_d   = S_CLEAR;
          end else begin
            sh_row_d    = row_q;
            sh_col_d    = col_q;
            sh_ph_d     = ph_q;
            sh_filled_d = filled_q;
            sh_top_d    = top_q;
            case (in_i.char_code) inside
              tcc_pkg::CH_NL, tcc_pkg::CH_CR: begin
                op_d   = tcc_pkg::ADV_LINE;
                char_d = tcc_pkg::CH_END;
                cnt_d  = CntW'(1);
              end
              tcc_pkg::CH_TAB: begin
                op_d   = tcc_pkg::ADV_COLUMN;
                char_d = tcc_pkg::CH_SPACE;
                cnt_d  = tab_cnt;
              end
              default: begin
                op_d   = tcc_pkg::ADV_COLUMN;
                char_d = in_i.char_code;
                cnt_d  = CntW'(1);
              end
            endcase
            prep_cnt_d = cnt_d;
            state_d    = S_PREP;
          end
        end
      end

      // Run every advance on the shadow to learn the top row after the item.
      S_PREP: begin
        sh_row_d    = a_row_o;
        sh_col_d    = a_col_o;
        sh_ph_d     = a_ph_o;
        sh_filled_d = a_filled_o;
        sh_top_d    = a_top_o;
        prep_cnt_d  = CntW'(prep_cnt_q - 1'b1);
        if (prep_cnt_q == CntW'(1)) begin
          final_top_d = a_top_o;
          state_d     = S_EMIT_CHAR;
        end
      end

      // Write the character at the cursor, then advance the cursor.
      S_EMIT_CHAR: begin
        if (out_free) begin
          emit_go  = 1'b1;
          o_row_d  = RowOutW'(row_q);
          o_col_d  = ColOutW'(col_q);
          o_char_d = char_q;
          o_top_d  = RowOutW'(final_top_q);
          o_last_d = 1'b0;
          row_d    = a_row_o;
          col_d    = a_col_o;
          ph_d     = a_ph_o;
          filled_d = a_filled_o;
          top_d    = a_top_o;
          state_d  = S_EMIT_END;
        end
      end

      // Terminate the row text at the new cursor.
      S_EMIT_END: begin
        if (out_free) begin
          emit_go   = 1'b1;
          emit_last = (cnt_q == CntW'(1));
          o_row_d   = RowOutW'(row_q);
          o_col_d   = ColOutW'(col_q);
          o_char_d  = tcc_pkg::CH_END;
          o_top_d   = RowOutW'(final_top_q);
          o_last_d  = emit_last;
          cnt_d     = CntW'(cnt_q - 1'b1);
          state_d   = emit_last ? S_IDLE : S_EMIT_CHAR;
        end
      end

      // Terminate column zero of every row, then return to the home state.
      S_CLEAR: begin
        if (out_free) begin
          emit_go   = 1'b1;
          emit_last = (clr_row_q == RowW'(ROWS - 1));
          o_row_d   = RowOutW'(clr_row_q);
          o_col_d   = '0;
          o_char_d  = tcc_pkg::CH_END;
          o_top_d   = '0;
          o_last_d  = emit_last;
          clr_row_d = RowW'(clr_row_q + 1'b1);
          if (emit_last) begin
            row_d    = '0;
            col_d    = '0;
            ph_d     = '0;
            filled_d = 1'b0;
            top_d    = '0;
            state_d  = S_IDLE;
          end
        end
      end

      default: state_d = S_IDLE;
    endcase

    out_valid_d = emit_go || (out_valid_q && !out_o.ready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      row_q       <= '0;
      col_q       <= '0;
      ph_q        <= '0;
      filled_q    <= 1'b0;
      top_q       <= '0;
      sh_row_q    <= '0;
      sh_col_q    <= '0;
      sh_ph_q     <= '0;
      sh_filled_q <= 1'b0;
      sh_top_q    <= '0;
      op_q        <= tcc_pkg::ADV_COLUMN;
      char_q      <= '0;
      cnt_q       <= '0;
      prep_cnt_q  <= '0;
      final_top_q <= '0;
      clr_row_q   <= '0;
      out_valid_q <= 1'b0;
      o_row_q     <= '0;
      o_col_q     <= '0;
      o_char_q    <= '0;
      o_top_q     <= '0;
      o_last_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      row_q       <= row_d;
      col_q       <= col_d;
      ph_q        <= ph_d;
      filled_q    <= filled_d;
      top_q       <= top_d;
      sh_row_q    <= sh_row_d;
      sh_col_q    <= sh_col_d;
      sh_ph_q     <= sh_ph_d;
      sh_filled_q <= sh_filled_d;
      sh_top_q    <= sh_top_d;
      op_q        <= op_d;
      char_q      <= char_d;
      cnt_q       <= cnt_d;
      prep_cnt_q  <= prep_cnt_d;
      final_top_q <= final_top_d;
      clr_row_q   <= clr_row_d;
      out_valid_q <= out_valid_d;
      o_row_q     <= o_row_d;
      o_col_q     <= o_col_d;
      o_char_q    <= o_char_d;
      o_top_q     <= o_top_d;
      o_last_q    <= o_last_d;
    end
  end

  // Port drive.
  assign in_i.ready         = (state_q == S_IDLE);
  assign out_o.valid        = out_valid_q;
  assign out_o.write_row    = o_row_q;
  assign out_o.write_column = o_col_q;
  assign out_o.write_char   = o_char_q;
  assign out_o.top_row      = o_top_q;
  assign out_o.last         = o_last_q;

  // The cursor stays inside the screen.
  `ASSERT_ALWAYS(a_cursor_range, clk_i, rst_ni,
                 (row_q <= RowW'(ROWS - 1)) && (col_q <= ColW'(COLUMNS - 1)))
  // The look-ahead pass never starts with nothing to do.
  `ASSERT_SAME(a_prep_nonzero, clk_i, rst_ni, state_q == S_PREP, prep_cnt_q != '0)
  // The final word of an item returns the sequencer to idle.
  `ASSERT_NEXT(a_last_idle, clk_i, rst_ni, emit_go && emit_last, state_q == S_IDLE)
  // The emit pass ends on the top row found by the look-ahead pass.
  `ASSERT_NEXT(a_top_match, clk_i, rst_ni,
               (state_q == S_EMIT_END) && emit_go && emit_last, top_q == final_top_q)

endmodule
